// ----- src/prc_pkg.sv -----
package prc_pkg;

    localparam int GUARD     = 4;
    localparam int ANG_W     = 35;
    localparam int ANGLE_W   = 31;
    localparam int K_W       = 30;
    localparam int ATAN_LEN  = 41;
    localparam int CW_MIN    = 16;
    localparam int CW_MAX    = 56;

    typedef logic signed [ANG_W-1:0] t_angle;

    localparam t_angle ANG_PI      = 35'sd3373259426;
    localparam t_angle ANG_NEG_PI  = -35'sd3373259426;
    localparam t_angle ANG_HALF_PI = 35'sd1686629713;
    localparam t_angle ANG_NEG_HALF_PI = -35'sd1686629713;
    localparam t_angle ANG_TWO_PI  = 35'sd6746518852;

    localparam logic [K_W-1:0] ATAN_Q30 [ATAN_LEN] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFD, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
        30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
        30'h00000001, 30'h0, 30'h0, 30'h0, 30'h0, 30'h0, 30'h0, 30'h0, 30'h0,
        30'h0, 30'h0
    };

    // CORDIC gain compensation in Q30, evaluated at elaboration
    function automatic logic [K_W-1:0] gain_q30(input int stages);
        logic [63:0] g;
        logic [63:0] res;
        logic [63:0] bt;
        logic [63:0] num;
        logic [64:0] rem;
        logic [63:0] q;
        g   = 64'd1 << 60;
        res = '0;
        bt  = 64'd1 << 62;
        q   = '0;
        rem = '0;
        for (int i = 0; i < stages; i++) begin
            if (2 * i < 64) begin
                g = g + (g >> (2 * i));
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (bt > g) begin
                bt = bt >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (bt != 0) begin
                if (g >= res + bt) begin
                    g   = g - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
        end
        num = (64'd1 << 60) + (res >> 1);
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, res}) begin
                rem  = rem - {1'b0, res};
                q[b] = 1'b1;
            end
        end
        return q[K_W-1:0];
    endfunction

endpackage

// ----- src/prc_if.sv -----
interface prc_in_if #(parameter int COORD_WIDTH = 32) ();
    import prc_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [ANGLE_W-1:0]     angle;

    modport source (output valid, point_x, point_y, center_x, center_y, angle,
                    input ready);
    modport sink (input valid, point_x, point_y, center_x, center_y, angle,
                  output ready);
endinterface

interface prc_out_if #(parameter int COORD_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] rotated_x;
    logic signed [COORD_WIDTH-1:0] rotated_y;
    logic                          overflow;

    modport source (output valid, rotated_x, rotated_y, overflow, input ready);
    modport sink (input valid, rotated_x, rotated_y, overflow, output ready);
endinterface

// ----- src/prc_prescale.sv -----
module prc_prescale #(
    parameter int CW     = 32,
    parameter int XW     = 39,
    parameter int STAGES = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [CW-1:0]  i_px,
    input  logic signed [CW-1:0]  i_py,
    input  logic signed [CW-1:0]  i_cx,
    input  logic signed [CW-1:0]  i_cy,
    input  logic signed [prc_pkg::ANGLE_W-1:0] i_angle,
    output logic                  o_valid,
    output logic signed [XW-1:0]  o_x,
    output logic signed [XW-1:0]  o_y,
    output prc_pkg::t_angle       o_z,
    output logic signed [CW-1:0]  o_cx,
    output logic signed [CW-1:0]  o_cy
);
    import prc_pkg::*;

    localparam int MW = (CW + 4 > 31) ? CW + 4 : 31;
    localparam logic [K_W-1:0] K = gain_q30(STAGES);

    // stage A: offsets, magnitude/sign, angle fold
    logic signed [CW:0] w_dx, w_dy;
    logic [CW+4:0]      w_dx16, w_dy16, w_ax, w_ay;
    t_angle             w_za, w_zf;

    assign w_dx   = {i_px[CW-1], i_px} - {i_cx[CW-1], i_cx};
    assign w_dy   = {i_py[CW-1], i_py} - {i_cy[CW-1], i_cy};
    assign w_dx16 = {w_dx, 4'b0000};
    assign w_dy16 = {w_dy, 4'b0000};
    assign w_ax   = w_dx[CW] ? (~w_dx16 + 1'b1) : w_dx16;
    assign w_ay   = w_dy[CW] ? (~w_dy16 + 1'b1) : w_dy16;
    assign w_za   = {{2{i_angle[ANGLE_W-1]}}, i_angle, 2'b00};

    always_comb begin
        priority if (w_za > ANG_PI) begin
            w_zf = w_za - ANG_TWO_PI;
        end else if (w_za <= ANG_NEG_PI) begin
            w_zf = w_za + ANG_TWO_PI;
        end else begin
            w_zf = w_za;
        end
    end

    logic              r_a_v;
    logic [MW-1:0]     r_a_mx, r_a_my;
    logic              r_a_nx, r_a_ny;
    t_angle            r_a_z;
    logic signed [CW-1:0] r_a_cx, r_a_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
        if (i_en) begin
            r_a_mx <= MW'(w_ax[CW+3:0]);
            r_a_my <= MW'(w_ay[CW+3:0]);
            r_a_nx <= w_dx[CW];
            r_a_ny <= w_dy[CW];
            r_a_z  <= w_zf;
            r_a_cx <= i_cx;
            r_a_cy <= i_cy;
        end
    end

    // stage B: low partial products
    logic                 r_b_v;
    logic [2*K_W-1:0]     r_b_lx, r_b_ly;
    logic [MW-31:0]       r_b_hx, r_b_hy;
    logic                 r_b_nx, r_b_ny;
    t_angle               r_b_z;
    logic signed [CW-1:0] r_b_cx, r_b_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_b_v <= r_a_v;
        end
        if (i_en) begin
            r_b_lx <= r_a_mx[K_W-1:0] * K;
            r_b_ly <= r_a_my[K_W-1:0] * K;
            r_b_hx <= r_a_mx[MW-1:K_W];
            r_b_hy <= r_a_my[MW-1:K_W];
            r_b_nx <= r_a_nx;
            r_b_ny <= r_a_ny;
            r_b_z  <= r_a_z;
            r_b_cx <= r_a_cx;
            r_b_cy <= r_a_cy;
        end
    end

    // stage C: high partial products, sign, quarter turn
    logic [MW-1:0]        w_hkx, w_hky;
    logic [MW:0]          w_pxw, w_pyw;
    logic signed [XW-1:0] w_ux, w_uy, w_sx, w_sy;
    logic signed [XW-1:0] n_x, n_y;
    t_angle               n_z;

    assign w_hkx = r_b_hx * K;
    assign w_hky = r_b_hy * K;
    assign w_pxw = {1'b0, w_hkx} + (MW+1)'(r_b_lx[2*K_W-1:K_W]);
    assign w_pyw = {1'b0, w_hky} + (MW+1)'(r_b_ly[2*K_W-1:K_W]);
    assign w_ux  = XW'(w_pxw[CW+3:0]);
    assign w_uy  = XW'(w_pyw[CW+3:0]);
    assign w_sx  = r_b_nx ? -w_ux : w_ux;
    assign w_sy  = r_b_ny ? -w_uy : w_uy;

    always_comb begin
        priority if (r_b_z > ANG_HALF_PI) begin
            n_x = -w_sy;
            n_y = w_sx;
            n_z = r_b_z - ANG_HALF_PI;
        end else if (r_b_z < ANG_NEG_HALF_PI) begin
            n_x = w_sy;
            n_y = -w_sx;
            n_z = r_b_z + ANG_HALF_PI;
        end else begin
            n_x = w_sx;
            n_y = w_sy;
            n_z = r_b_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_b_v;
        end
        if (i_en) begin
            o_x  <= n_x;
            o_y  <= n_y;
            o_z  <= n_z;
            o_cx <= r_b_cx;
            o_cy <= r_b_cy;
        end
    end

endmodule

// ----- src/prc_cell.sv -----
module prc_cell #(
    parameter int               CW    = 32,
    parameter int               XW    = 39,
    parameter int               SHIFT = 0,
    parameter logic [29:0]      ATAN  = 30'h0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [XW-1:0]  i_x,
    input  logic signed [XW-1:0]  i_y,
    input  prc_pkg::t_angle       i_z,
    input  logic signed [CW-1:0]  i_cx,
    input  logic signed [CW-1:0]  i_cy,
    output logic                  o_valid,
    output logic signed [XW-1:0]  o_x,
    output logic signed [XW-1:0]  o_y,
    output prc_pkg::t_angle       o_z,
    output logic signed [CW-1:0]  o_cx,
    output logic signed [CW-1:0]  o_cy
);
    import prc_pkg::*;

    logic signed [XW-1:0] w_xs, w_ys;
    t_angle               w_a;
    logic                 w_pos;

    assign w_xs  = i_x >>> SHIFT;
    assign w_ys  = i_y >>> SHIFT;
    assign w_a   = {{(ANG_W-K_W){1'b0}}, ATAN};
    assign w_pos = !i_z[ANG_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_x  <= w_pos ? i_x - w_ys : i_x + w_ys;
            o_y  <= w_pos ? i_y + w_xs : i_y - w_xs;
            o_z  <= w_pos ? i_z - w_a : i_z + w_a;
            o_cx <= i_cx;
            o_cy <= i_cy;
        end
    end

endmodule

// ----- src/prc_finish.sv -----
module prc_finish #(
    parameter int COORD_WIDTH = 32,
    parameter int CW          = 32,
    parameter int XW          = 39
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic signed [XW-1:0]  i_x,
    input  logic signed [XW-1:0]  i_y,
    input  logic signed [CW-1:0]  i_cx,
    input  logic signed [CW-1:0]  i_cy,
    output logic                  o_en,
    prc_out_if.source             o_rot
);
    import prc_pkg::*;

    localparam int FW = CW + 8;
    localparam logic signed [FW-1:0] SAT_HI = {{(FW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [FW-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [FW-1:0] RND    = FW'(1 << (GUARD - 1));

    logic signed [FW-1:0] w_vx, w_vy, w_rx, w_ry;
    logic                 w_ox, w_oy;
    logic [CW-1:0]        w_qx, w_qy;

    assign w_vx = {i_x[XW-1], i_x} + {{GUARD{i_cx[CW-1]}}, i_cx, {GUARD{1'b0}}} + RND;
    assign w_vy = {i_y[XW-1], i_y} + {{GUARD{i_cy[CW-1]}}, i_cy, {GUARD{1'b0}}} + RND;
    assign w_rx = w_vx >>> GUARD;
    assign w_ry = w_vy >>> GUARD;
    assign w_ox = (w_rx > SAT_HI) || (w_rx < SAT_LO);
    assign w_oy = (w_ry > SAT_HI) || (w_ry < SAT_LO);
    assign w_qx = (w_rx > SAT_HI) ? SAT_HI[CW-1:0] :
                  (w_rx < SAT_LO) ? SAT_LO[CW-1:0] : w_rx[CW-1:0];
    assign w_qy = (w_ry > SAT_HI) ? SAT_HI[CW-1:0] :
                  (w_ry < SAT_LO) ? SAT_LO[CW-1:0] : w_ry[CW-1:0];

    logic          r_out_v, r_out_ovf, r_sk_v, r_sk_ovf;
    logic [CW-1:0] r_out_x, r_out_y, r_sk_x, r_sk_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (o_rot.ready || !r_out_v) begin
            r_out_v <= r_sk_v || i_valid;
            r_sk_v  <= 1'b0;
        end else if (i_valid) begin
            r_sk_v <= 1'b1;
        end
        if (o_rot.ready || !r_out_v) begin
            if (r_sk_v) begin
                r_out_x   <= r_sk_x;
                r_out_y   <= r_sk_y;
                r_out_ovf <= r_sk_ovf;
            end else begin
                r_out_x   <= w_qx;
                r_out_y   <= w_qy;
                r_out_ovf <= w_ox || w_oy;
            end
        end else if (i_valid) begin
            r_sk_x   <= w_qx;
            r_sk_y   <= w_qy;
            r_sk_ovf <= w_ox || w_oy;
        end
    end

    assign o_en            = !r_sk_v;
    assign o_rot.valid     = r_out_v;
    assign o_rot.rotated_x = COORD_WIDTH'(r_out_x);
    assign o_rot.rotated_y = COORD_WIDTH'(r_out_y);
    assign o_rot.overflow  = r_out_ovf;

    a_skid_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_out_v) else $error("skid word without output word");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !r_sk_v) else $error("word pushed into full skid");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !o_rot.ready && i_valid) |=> r_sk_v)
        else $error("stalled word not held in skid");

    a_ovf_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_ovf) |->
        (r_out_x == SAT_HI[CW-1:0] || r_out_x == SAT_LO[CW-1:0] ||
         r_out_y == SAT_HI[CW-1:0] || r_out_y == SAT_LO[CW-1:0]))
        else $error("overflow flag without saturated coordinate");

endmodule

// ----- src/point_rotate_about_center.sv -----
// Pipeline: 3 prescale stages, one CORDIC cell per stage and one output register
// lie between the input word and the output word.
// Throughput: one word per cycle while ready is high; a two-entry output
// register/skid pair keeps input ready high until both hold an untaken word.
// Reset: synchronous active-low reset clears all valid bits; no payload reset.
module point_rotate_about_center #(
    parameter int COORD_WIDTH   = 32,
    parameter int CORDIC_STAGES = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    prc_in_if.sink     i_pnt,
    prc_out_if.source  o_rot
);
    import prc_pkg::*;

    localparam int CW = (COORD_WIDTH < CW_MIN) ? CW_MIN :
                        ((COORD_WIDTH > CW_MAX) ? CW_MAX : COORD_WIDTH);
    localparam int XW = CW + 7;
    localparam int N  = CORDIC_STAGES;

    logic                 w_en;
    logic                 w_v  [0:N];
    logic signed [XW-1:0] w_x  [0:N];
    logic signed [XW-1:0] w_y  [0:N];
    t_angle               w_z  [0:N];
    logic signed [CW-1:0] w_cx [0:N];
    logic signed [CW-1:0] w_cy [0:N];

    assign i_pnt.ready = w_en;

    prc_prescale #(.CW(CW), .XW(XW), .STAGES(N)) u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_pnt.valid),
        .i_px    (i_pnt.point_x[CW-1:0]),
        .i_py    (i_pnt.point_y[CW-1:0]),
        .i_cx    (i_pnt.center_x[CW-1:0]),
        .i_cy    (i_pnt.center_y[CW-1:0]),
        .i_angle (i_pnt.angle),
        .o_valid (w_v[0]),
        .o_x     (w_x[0]),
        .o_y     (w_y[0]),
        .o_z     (w_z[0]),
        .o_cx    (w_cx[0]),
        .o_cy    (w_cy[0])
    );

    for (genvar i = 0; i < N; i++) begin : g_cell
        prc_cell #(.CW(CW), .XW(XW), .SHIFT(i), .ATAN(ATAN_Q30[i])) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[i]),
            .i_x     (w_x[i]),
            .i_y     (w_y[i]),
            .i_z     (w_z[i]),
            .i_cx    (w_cx[i]),
            .i_cy    (w_cy[i]),
            .o_valid (w_v[i+1]),
            .o_x     (w_x[i+1]),
            .o_y     (w_y[i+1]),
            .o_z     (w_z[i+1]),
            .o_cx    (w_cx[i+1]),
            .o_cy    (w_cy[i+1])
        );
    end

    prc_finish #(.COORD_WIDTH(COORD_WIDTH), .CW(CW), .XW(XW)) u_fin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v[N] && w_en),
        .i_x     (w_x[N]),
        .i_y     (w_y[N]),
        .i_cx    (w_cx[N]),
        .i_cy    (w_cy[N]),
        .o_en    (w_en),
        .o_rot   (o_rot)
    );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import prc_pkg::*;

    localparam int CW          = 32;
    localparam int STAGES      = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_WORDS  = 1250;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN       = STAGES + 16;

    localparam longint Q30_PI      = 64'sd3373259426;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint Q30_TWO_PI  = 64'sd6746518852;

    localparam logic signed [CW-1:0] C_MAX = 32'sh7FFFFFFF;
    localparam logic signed [CW-1:0] C_MIN = 32'sh80000000;
    localparam logic signed [CW-1:0] C_ONE = 32'sh00010000;

    // Q3.28 angles just inside and just past a quarter and a half turn
    localparam logic signed [ANGLE_W-1:0] A_QTR_IN  = 31'sd421657428;
    localparam logic signed [ANGLE_W-1:0] A_QTR_OUT = 31'sd421657429;
    localparam logic signed [ANGLE_W-1:0] A_PI_IN   = 31'sd843314856;
    localparam logic signed [ANGLE_W-1:0] A_PI_OUT  = 31'sd843314857;
    localparam logic signed [ANGLE_W-1:0] A_MAX     = 31'sd1073741823;
    localparam logic signed [ANGLE_W-1:0] A_MIN     = -31'sd1073741824;

    localparam logic [29:0] ATAN_TBL [0:30] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFD, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
        30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
        30'h00000001
    };

    typedef struct packed {
        logic signed [CW-1:0]      px;
        logic signed [CW-1:0]      py;
        logic signed [CW-1:0]      cx;
        logic signed [CW-1:0]      cy;
        logic signed [ANGLE_W-1:0] ang;
    } t_pnt_word;

    typedef struct packed {
        logic signed [CW-1:0] rx;
        logic signed [CW-1:0] ry;
        logic                 ovf;
    } t_rot_word;

    class t_rotation_scoreboard;
        t_rot_word       expected_rotations[$];
        int              errors;
        longint unsigned gain;

        function new();
            longint unsigned g, res, bt;
            g   = 64'd1 << 60;
            res = 0;
            bt  = 64'd1 << 62;
            errors = 0;
            for (int i = 0; i < STAGES; i++) begin
                if (2 * i < 64) begin
                    g = g + (g >> (2 * i));
                end
            end
            while (bt > g) begin
                bt = bt >> 2;
            end
            while (bt != 0) begin
                if (g >= res + bt) begin
                    g   = g - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
            gain = ((64'd1 << 60) + res / 2) / res;
        endfunction

        function longint scale_by_gain(longint a);
            longint unsigned ua, hi, lo, p;
            ua = (a < 0) ? -a : a;
            hi = ua >> 30;
            lo = ua & ((64'd1 << 30) - 1);
            p  = hi * gain + ((lo * gain) >> 30);
            return (a < 0) ? -longint'(p) : longint'(p);
        endfunction

        function logic signed [CW-1:0] round_clamp(longint v, ref logic ovf);
            longint r;
            r = (v + 8) >>> GUARD;
            if (r > longint'(C_MAX)) begin
                ovf = 1'b1;
                return C_MAX;
            end
            if (r < longint'(C_MIN)) begin
                ovf = 1'b1;
                return C_MIN;
            end
            return r[CW-1:0];
        endfunction

        function t_rot_word rotate_about_center(t_pnt_word w);
            longint    z, x, y, t, xs, ys, a;
            t_rot_word r;
            logic      ovf;
            ovf = 1'b0;
            z = longint'(w.ang) * 4;
            if (z > Q30_PI) begin
                z = z - Q30_TWO_PI;
            end else if (z <= -Q30_PI) begin
                z = z + Q30_TWO_PI;
            end
            x = scale_by_gain((longint'(w.px) - longint'(w.cx)) * 16);
            y = scale_by_gain((longint'(w.py) - longint'(w.cy)) * 16);
            if (z > Q30_HALF_PI) begin
                t = x; x = -y; y = t;
                z = z - Q30_HALF_PI;
            end else if (z < -Q30_HALF_PI) begin
                t = x; x = y; y = -t;
                z = z + Q30_HALF_PI;
            end
            for (int i = 0; i < STAGES; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                a  = (i < 31) ? longint'(ATAN_TBL[i]) : 0;
                if (z >= 0) begin
                    x = x - ys; y = y + xs; z = z - a;
                end else begin
                    x = x + ys; y = y - xs; z = z + a;
                end
            end
            r.rx  = round_clamp(x + longint'(w.cx) * 16, ovf);
            r.ry  = round_clamp(y + longint'(w.cy) * 16, ovf);
            r.ovf = ovf;
            return r;
        endfunction

        function void note_point(t_pnt_word w);
            expected_rotations.push_back(rotate_about_center(w));
        endfunction

        function void report(string field, logic signed [CW-1:0] e,
                             logic signed [CW-1:0] a);
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, e, a);
        endfunction

        function void check_rotated(t_rot_word got);
            t_rot_word exp_w;
            if (expected_rotations.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: expected none, got x=%0d y=%0d ovf=%0b",
                         $time, got.rx, got.ry, got.ovf);
                return;
            end
            exp_w = expected_rotations.pop_front();
            if (got.rx !== exp_w.rx) report("rotated_x", exp_w.rx, got.rx);
            if (got.ry !== exp_w.ry) report("rotated_y", exp_w.ry, got.ry);
            if (got.ovf !== exp_w.ovf) report("overflow", exp_w.ovf, got.ovf);
        endfunction

        function int pending();
            return expected_rotations.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   idle_pct = 0;
    bit   hold_req = 1'b0;
    int   cycle_cnt = 0;

    t_rotation_scoreboard sb = new();

    prc_in_if  #(.COORD_WIDTH(CW)) pnt_if ();
    prc_out_if #(.COORD_WIDTH(CW)) rot_if ();

    point_rotate_about_center #(
        .COORD_WIDTH   (CW),
        .CORDIC_STAGES (STAGES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pnt   (pnt_if),
        .o_rot   (rot_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // receiver: random stalls plus one long hold-off on request
    initial begin
        int stall;
        t_rot_word got;
        stall = 0;
        rot_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rot_if.valid && rot_if.ready) begin
                got.rx  = rot_if.rotated_x;
                got.ry  = rot_if.rotated_y;
                got.ovf = rot_if.overflow;
                sb.check_rotated(got);
            end
            if (hold_req) begin
                stall    = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                rot_if.ready <= 1'b0;
                stall--;
            end else if (i_rst_n && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                rot_if.ready <= 1'b0;
                stall = $urandom_range(1, 18) - 1;
            end else begin
                rot_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input t_pnt_word w);
        pnt_if.valid    <= 1'b1;
        pnt_if.point_x  <= w.px;
        pnt_if.point_y  <= w.py;
        pnt_if.center_x <= w.cx;
        pnt_if.center_y <= w.cy;
        pnt_if.angle    <= w.ang;
        do @(posedge i_clk); while (!pnt_if.ready);
        sb.note_point(w);
    endtask

    task automatic send_point(input logic signed [CW-1:0] px, input logic signed [CW-1:0] py,
                              input logic signed [CW-1:0] cx, input logic signed [CW-1:0] cy,
                              input logic signed [ANGLE_W-1:0] ang);
        t_pnt_word w;
        w.px = px; w.py = py; w.cx = cx; w.cy = cy; w.ang = ang;
        send_word(w);
    endtask

    task automatic sender_gap();
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            pnt_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        pnt_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic signed [ANGLE_W-1:0] edge_angle();
        logic signed [ANGLE_W-1:0] a;
        case ($urandom_range(4))
            0: a = A_QTR_IN;
            1: a = A_PI_IN;
            2: a = A_MAX;
            3: a = '0;
            default: a = ANGLE_W'($urandom);
        endcase
        if ($urandom_range(1)) a = -a;
        return a + $signed(4'($urandom_range(15))) ;
    endfunction

    function automatic t_pnt_word random_point();
        t_pnt_word w;
        int        sel;
        sel   = $urandom_range(99);
        w.ang = ANGLE_W'($urandom);
        if (sel < 40) begin
            w.px = $signed($urandom) >>> 7;
            w.py = $signed($urandom) >>> 7;
            w.cx = $signed($urandom) >>> 7;
            w.cy = $signed($urandom) >>> 7;
        end else if (sel < 70) begin
            w.px = $urandom;
            w.py = $urandom;
            w.cx = $urandom;
            w.cy = $urandom;
        end else if (sel < 85) begin
            // center near a bound so the result clamps or just misses
            w.cx = $urandom_range(1) ? C_MAX - ($urandom & 32'hFFFFF) : C_MIN + ($urandom & 32'hFFFFF);
            w.cy = $urandom_range(1) ? C_MAX - ($urandom & 32'hFFFFF) : C_MIN + ($urandom & 32'hFFFFF);
            w.px = w.cx + ($signed($urandom) >>> 12);
            w.py = w.cy + ($signed($urandom) >>> 12);
        end else begin
            w.px  = $signed($urandom) >>> 10;
            w.py  = $signed($urandom) >>> 10;
            w.cx  = $signed($urandom) >>> 10;
            w.cy  = $signed($urandom) >>> 10;
            w.ang = edge_angle();
        end
        return w;
    endfunction

    initial begin
        i_rst_n         <= 1'b0;
        pnt_if.valid    <= 1'b0;
        pnt_if.point_x  <= '0;
        pnt_if.point_y  <= '0;
        pnt_if.center_x <= '0;
        pnt_if.center_y <= '0;
        pnt_if.angle    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_point(C_ONE, 0, 0, 0, '0);
        send_point(C_ONE, 0, 0, 0, A_QTR_IN);
        send_point(C_ONE, 0, 0, 0, A_QTR_OUT);
        send_point(C_ONE, 0, 0, 0, -A_QTR_IN);
        send_point(C_ONE, 0, 0, 0, -A_QTR_OUT);
        send_point(C_ONE, C_ONE, 0, 0, A_PI_IN);
        send_point(C_ONE, C_ONE, 0, 0, A_PI_OUT);
        send_point(-C_ONE, C_ONE, 0, 0, -A_PI_IN);
        send_point(-C_ONE, C_ONE, 0, 0, -A_PI_OUT);
        send_point(C_ONE, -C_ONE, C_ONE, 0, A_MAX);
        send_point(C_ONE, -C_ONE, 0, C_ONE, A_MIN);
        send_point(C_MAX, C_MAX, C_MIN, C_MIN, '0);
        send_point(C_MIN, C_MIN, C_MAX, C_MAX, A_QTR_IN);
        send_point(C_MAX, C_MIN, C_MIN, C_MAX, A_MIN);
        send_point(0, 0, 0, 0, '0);
        send_point(C_MAX, C_MAX, C_MAX, C_MAX, A_PI_OUT);
        send_point(C_MIN + 100 + C_ONE, C_MIN, C_MIN + 100, C_MIN, A_PI_IN);
        send_point(C_ONE, C_MAX - 100, 0, C_MAX - 100, A_QTR_IN);
        send_point(-1, -1, 0, 0, 31'sd1);
        send_point(32'sh7FFF_FFFF, 32'sh0000_7FFF, 32'sh1234_5678, -32'sh0765_4321, -31'sd1);
        send_point(-32'sh4000_0000, 32'sh3FFF_FFFF, 32'sh3FFF_FFFF, -32'sh4000_0000, A_QTR_OUT);

        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n >= RAND_WORDS - 200) begin
                idle_pct = 0;
            end else if (n % 100 == 0) begin
                case ($urandom_range(2))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    default: idle_pct = 40;
                endcase
            end
            if (n == 300) hold_req = 1'b1;
            if (n == 700) wait_drained();
            send_word(random_point());
            sender_gap();
        end

        wait_drained();
        repeat (DRAIN) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- point_rotate_about_center.f -----
src/prc_pkg.sv
src/prc_if.sv
src/prc_prescale.sv
src/prc_cell.sv
src/prc_finish.sv
src/point_rotate_about_center.sv
verif/testbench.sv
